[design/salted_sha1_nid_encoder_macros.svh]
// Assertion macros shared by the encoder modules.
// No dependencies.
`ifndef SALTED_SHA1_NID_ENCODER_MACROS_SVH
`define SALTED_SHA1_NID_ENCODER_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define SSN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define SSN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

[design/ssn_pkg.sv]
// Shared constants, types and functions of the salted SHA-1 identifier encoder.
// No dependencies.
package ssn_pkg;
  localparam int unsigned MaxSaltBytes = 16;
  localparam int unsigned IdChars      = 11;
  localparam int unsigned QDepth       = 4;

  localparam logic [1:0] RegMode      = 2'd0;
  localparam logic [1:0] RegSaltFirst = 2'd1;
  localparam logic [1:0] RegSaltLast  = 2'd2;
  localparam logic [1:0] RegSaltLen   = 2'd3;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  // One classified byte for the back end: a message byte, with end-of-name mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } ssn_item_t;

  // Latched configuration as the back end sees it.
  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] salt_first;
    logic [63:0] salt_last;
    logic [4:0]  salt_len;
  } ssn_cfg_t;

  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] c;
    if (idx < 6'd26)      c = 7'd65 + {1'b0, idx};
    else if (idx < 6'd52) c = 7'd71 + {1'b0, idx};
    else if (idx < 6'd62) c = {1'b0, idx} - 7'd4;
    else if (idx == 6'd62) c = 7'd43;
    else                  c = 7'd45;
    return c;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction
endpackage

[design/ssn_stream_if.sv]
// Valid/ready channel interface for byte input and character output.
// No dependencies; the payload widths are fixed in the interfaces.
interface ssn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       last_byte;
  modport source (output valid, output name_byte, output last_byte, input ready);
  modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface ssn_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] nid_char;
  logic       last_char;
  modport source (output valid, output nid_char, output last_char, input ready);
  modport sink   (input valid, input nid_char, input last_char, output ready);
endinterface

[design/salted_sha1_nid_encoder.sv]
// Salted SHA-1 symbol identifier encoder: sequential, one name at a time.
// Throughput: one byte per cycle into the block while in the name state, then each
// 64-byte block stalls intake for its 80 rounds and the chaining add.
// Path: the queue registers each byte; after the last byte come the salt bytes, one
// per cycle, a step into padding, padding to the block end, compression of each
// final block (one or two), then 11 characters, one per accepted cycle. Reset (async,
// active low) restores the chaining values and clears the queue.
module salted_sha1_nid_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssn_in_if.sink      in_if,
  ssn_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import ssn_pkg::*;

  ssn_cfg_t  cfg_q;
  ssn_item_t item;
  logic      item_valid, item_pop;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:      cfg_q.mode       <= cfg_data_i[2:0];
        RegSaltFirst: cfg_q.salt_first <= cfg_data_i;
        RegSaltLast:  cfg_q.salt_last  <= cfg_data_i;
        RegSaltLen:   cfg_q.salt_len   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  ssn_front u_front (
    .clk_i, .rst_ni, .in_if,
    .item_o(item), .item_valid_o(item_valid), .item_pop_i(item_pop)
  );

  ssn_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .item_i(item), .item_valid_i(item_valid), .item_pop_o(item_pop), .out_if
  );
endmodule

[design/ssn_front.sv]
// Input front end: takes name bytes and queues them for the hash engine.
// Depends on ssn_pkg and ssn_stream_if.
module ssn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssn_in_if.sink            in_if,
  output ssn_pkg::ssn_item_t item_o,
  output logic              item_valid_o,
  input  logic              item_pop_i
);
  import ssn_pkg::*;

  localparam int unsigned AW = $clog2(QDepth);

  ssn_item_t         mem_q [QDepth];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;
  logic              push;

  assign in_if.ready  = (cnt_q != QDepth[AW:0]);
  assign push         = in_if.valid && in_if.ready;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];

  // Store accepted bytes.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: in_if.name_byte, last: in_if.last_byte};
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (item_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, item_pop_i};
    end
  end

  `include "salted_sha1_nid_encoder_macros.svh"
  `SSN_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, item_pop_i, cnt_q != '0, "pop from empty queue")
  `SSN_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= QDepth[AW:0], "queue overfilled")
  `SSN_ASSERT_NXT(a_full_cnt, clk_i, rst_ni, push && !item_pop_i, cnt_q == $past(cnt_q) + 1'b1, "count lost")
endmodule

[design/ssn_back.sv]
// Hash back end: SHA-1 over name, salt and padding, then character output.
// Depends on ssn_pkg and ssn_stream_if.
module ssn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssn_pkg::ssn_cfg_t  cfg_i,
  input  ssn_pkg::ssn_item_t item_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  ssn_out_if.source          out_if
);
  import ssn_pkg::*;

  typedef enum logic [2:0] {
    S_NAME, S_SALT, S_PAD, S_COMP, S_FINAL, S_EMIT
  } state_e;

  state_e        state_q, ret_q;
  logic [31:0]   w_q [16];
  logic [31:0]   h_q [5];
  logic [31:0]   a_q, b_q, c_q, d_q, e_q;
  logic [6:0]    rnd_q;
  logic [60:0]   cnt_q;
  logic [5:0]    pos_q;
  logic [4:0]    salt_i_q, salt_n_q;
  logic [63:0]   bits_q;
  logic [3:0]    ch_q;
  logic          mark_q;      // 0x80 already placed
  logic          lenblk_q;    // current pad block carries the bit length
  logic [2:0]    mode_q;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        blk_end;
  logic [31:0] wnew, wcur, f, k, t;
  logic [7:0]  dig [20];
  logic [63:0] v_pack;
  logic [5:0]  grp;
  logic [7:0]  sb;
  logic [3:0]  wi;
  logic        little, lowfirst, hi_win;
  logic        char_done;

  assign item_pop_o = (state_q == S_NAME) && item_valid_i;
  assign wi         = rnd_q[3:0];

  // Salt byte selection.
  always_comb begin
    if (salt_i_q < 5'd8) sb = cfg_i.salt_first[8*(7-salt_i_q[2:0]) +: 8];
    else                 sb = cfg_i.salt_last[8*(7-salt_i_q[2:0]) +: 8];
  end

  // Round logic.
  always_comb begin
    wnew = rol(w_q[wi+4'd13] ^ w_q[wi+4'd8] ^ w_q[wi+4'd2] ^ w_q[wi], 1);
    wcur = (rnd_q >= 7'd16) ? wnew : w_q[wi];
    if (rnd_q < 7'd20)      begin f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999; end
    else if (rnd_q < 7'd40) begin f = b_q ^ c_q ^ d_q;            k = 32'h6ED9EBA1; end
    else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
    end else                begin f = b_q ^ c_q ^ d_q;            k = 32'hCA62C1D6; end
    t = rol(a_q, 5) + f + e_q + k + wcur;
  end

  // Digest packing.
  always_comb begin
    {dig[0], dig[1], dig[2], dig[3]}     = h_q[0];
    {dig[4], dig[5], dig[6], dig[7]}     = h_q[1];
    {dig[8], dig[9], dig[10], dig[11]}   = h_q[2];
    {dig[12], dig[13], dig[14], dig[15]} = h_q[3];
    {dig[16], dig[17], dig[18], dig[19]} = h_q[4];
    little = (mode_q == 3'd1) || (mode_q == 3'd2) || (mode_q == 3'd4) || (mode_q == 3'd7);
    hi_win = (mode_q >= 3'd6);
    v_pack = '0;
    for (int i = 0; i < 8; i++) begin
      if (little) v_pack[8*i +: 8] = hi_win ? dig[12+i] : dig[i];
      else        v_pack[8*(7-i) +: 8] = hi_win ? dig[12+i] : dig[i];
    end
  end

  // Character group for the current output slot.
  always_comb begin
    lowfirst = (mode_q == 3'd2) || (mode_q == 3'd3);
    if (lowfirst)           grp = 6'(v_pack >> (6*ch_q));
    else if (ch_q == 4'd10) grp = {v_pack[3:0], 2'b00};
    else                    grp = 6'(v_pack >> (58 - 6*ch_q));
  end

  assign out_if.valid     = (state_q == S_EMIT);
  assign out_if.nid_char  = b64_char(grp);
  assign out_if.last_char = (ch_q == 4'(IdChars - 1));
  assign char_done        = out_if.valid && out_if.ready && out_if.last_char;

  // Byte to place into the block this cycle.
  always_comb begin
    wr_en = 1'b0; wr_byte = 8'h00;
    case (state_q)
      S_NAME: begin wr_en = item_valid_i; wr_byte = item_i.data; end
      S_SALT: begin wr_en = (salt_i_q != salt_n_q); wr_byte = sb; end
      S_PAD: begin
        wr_en = 1'b1;
        if (!mark_q) wr_byte = 8'h80;
        else if (lenblk_q && pos_q[5:3] == 3'b111) wr_byte = bits_q[8*(7-pos_q[2:0]) +: 8];
        else wr_byte = 8'h00;
      end
      default: ;
    endcase
  end

  assign blk_end = wr_en && (pos_q == 6'd63);

  // Block bytes and rolling schedule.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      w_q[pos_q[5:2]][8*(3-pos_q[1:0]) +: 8] <= wr_byte;
    end else if (state_q == S_COMP) begin
      w_q[wi] <= wcur;
    end
  end

  // Sequencer: absorb, salt, pad, compress, finalize, emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_NAME; ret_q <= S_NAME;
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
      cnt_q <= '0; pos_q <= '0; rnd_q <= '0; salt_i_q <= '0; salt_n_q <= '0;
      ch_q <= '0; mark_q <= 1'b0; lenblk_q <= 1'b0; mode_q <= '0;
      bits_q <= '0;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
    end else begin
      case (state_q)
        S_NAME: if (item_valid_i) begin
          cnt_q <= cnt_q + 61'd1;
          pos_q <= pos_q + 6'd1;
          if (item_i.last) begin
            mode_q   <= cfg_i.mode;
            salt_n_q <= (cfg_i.salt_len > 5'(MaxSaltBytes)) ? 5'(MaxSaltBytes)
                                                            : cfg_i.salt_len;
            salt_i_q <= '0;
          end
          if (blk_end) begin
            state_q <= S_COMP; rnd_q <= '0;
            ret_q <= item_i.last ? S_SALT : S_NAME;
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
          end else if (item_i.last) state_q <= S_SALT;
        end
        S_SALT: begin
          if (salt_i_q == salt_n_q) begin
            // Salt exhausted: turn to padding.
            state_q <= S_PAD; mark_q <= 1'b0; lenblk_q <= 1'b0;
            bits_q <= {cnt_q, 3'b000};
          end else begin
            cnt_q <= cnt_q + 61'd1;
            pos_q <= pos_q + 6'd1;
            salt_i_q <= salt_i_q + 5'd1;
            if (blk_end) begin
              state_q <= S_COMP; rnd_q <= '0; ret_q <= S_SALT;
              a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
            end
          end
        end
        S_PAD: begin
          pos_q  <= pos_q + 6'd1;
          mark_q <= 1'b1;
          if (blk_end) begin
            state_q <= S_COMP; rnd_q <= '0;
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
            if (mark_q && lenblk_q) begin
              ret_q <= S_EMIT;
            end else begin
              ret_q <= S_PAD; lenblk_q <= 1'b1;
            end
          end else if (!mark_q) begin
            lenblk_q <= (pos_q < 6'd56);
          end
        end
        S_COMP: begin
          e_q <= d_q; d_q <= c_q; c_q <= rol(b_q, 30); b_q <= a_q; a_q <= t;
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) state_q <= S_FINAL;
        end
        S_FINAL: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
          state_q <= ret_q;
          ch_q <= '0;
        end
        S_EMIT: begin
          if (out_if.ready) begin
            if (ch_q == 4'(IdChars - 1)) begin
              state_q <= S_NAME; ch_q <= '0;
              h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
              cnt_q <= '0;
            end else begin
              ch_q <= ch_q + 4'd1;
            end
          end
        end
        default: state_q <= S_NAME;
      endcase
    end
  end

  `include "salted_sha1_nid_encoder_macros.svh"
  `SSN_ASSERT_IMP(a_pop_name, clk_i, rst_ni, item_pop_o, state_q == S_NAME, "pop outside name")
  `SSN_ASSERT_IMP(a_emit_idx, clk_i, rst_ni, out_if.valid, ch_q <= 4'd10, "char index past end")
  `SSN_ASSERT_NXT(a_last_wrap, clk_i, rst_ni, char_done, state_q == S_NAME, "no return after last")
endmodule

[tb/salted_sha1_nid_encoder_tb.sv]
// Testbench for salted_sha1_nid_encoder: streams directed and random names and checks each identifier.
// Depends on ssn_pkg, the ssn_in_if/ssn_out_if interfaces and the encoder top level.
`timescale 1ns / 100ps
module salted_sha1_nid_encoder_tb;
  import ssn_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } nid_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  ssn_in_if  in_if ();
  ssn_out_if out_if ();

  salted_sha1_nid_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Pending name bytes, expected characters, error count.
  ssn_item_t  name_q[$];
  nid_char_t  nid_q[$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         taken_cnt = 0;
  int         taken_seen = 0;

  // Predictor state and register copies.
  logic [31:0] chain[5];
  logic [7:0]  blk[64];
  logic [60:0] msg_count;
  logic [2:0]  m_mode;
  logic [63:0] m_salt_first;
  logic [63:0] m_salt_last;
  logic [4:0]  m_salt_len;

  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-";

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic chain_reset();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    chain[4] = 32'hC3D2E1F0;
    msg_count = '0;
  endtask

  // One SHA-1 compression over blk.
  task automatic sha1_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 0; i < 80; i++) begin
      if (i >= 16) begin
        w[i%16] = rot_left(w[(i+13)%16] ^ w[(i+8)%16] ^ w[(i+2)%16] ^ w[i%16], 1);
      end
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rot_left(a, 5) + f + e + k + w[i%16];
      e = d; d = c; c = rot_left(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    blk[msg_count[5:0]] = v;
    msg_count = msg_count + 1'b1;
    if (msg_count[5:0] == 6'd0) sha1_block();
  endtask

  task automatic pad_byte(inout int pos, input logic [7:0] v);
    blk[pos] = v;
    pos++;
    if (pos == 64) begin
      sha1_block();
      pos = 0;
    end
  endtask

  // Absorb one name byte; on the last one finish the digest and queue 11 characters.
  task automatic predict_nid(input logic [7:0] nb, input logic lb);
    int          n, pos, off;
    logic [63:0] bits, v;
    logic [7:0]  dig[20];
    logic [5:0]  idx;
    bit          little, lowfirst;
    nid_char_t   nc;
    absorb_byte(nb);
    if (lb) begin
      n = (int'(m_salt_len) > int'(MaxSaltBytes)) ? int'(MaxSaltBytes) : int'(m_salt_len);
      for (int i = 0; i < n; i++) begin
        if (i < 8) absorb_byte(m_salt_first[63 - 8*i -: 8]);
        else       absorb_byte(m_salt_last[63 - 8*(i-8) -: 8]);
      end
      bits = {msg_count, 3'b000};
      pos = int'(msg_count[5:0]);
      pad_byte(pos, 8'h80);
      while (pos != 56) pad_byte(pos, 8'h00);
      for (int i = 0; i < 8; i++) pad_byte(pos, bits[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) dig[4*i+j] = chain[i][31 - 8*j -: 8];
      end
      off = (m_mode >= 3'd6) ? 12 : 0;
      little = (m_mode == 3'd1 || m_mode == 3'd2 || m_mode == 3'd4 || m_mode == 3'd7);
      lowfirst = (m_mode == 3'd2 || m_mode == 3'd3);
      v = '0;
      for (int i = 0; i < 8; i++) begin
        if (little) v = v | (64'(dig[off+i]) << (8*i));
        else        v = {v[55:0], dig[off+i]};
      end
      for (int i = 0; i < IdChars; i++) begin
        if (lowfirst)    idx = 6'(v >> (6*i));
        else if (i < 10) idx = 6'(v >> (58 - 6*i));
        else             idx = {v[3:0], 2'b00};
        nc.ch = 7'(Alphabet[idx]);
        nc.last = (i == IdChars - 1);
        nid_q.push_back(nc);
      end
      chain_reset();
    end
  endtask

  // Register write at the falling edge; mirror into the predictor.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegMode:      m_mode = data[2:0];
      RegSaltFirst: m_salt_first = data;
      RegSaltLast:  m_salt_last = data;
      RegSaltLen:   m_salt_len = data[4:0];
      default: ;
    endcase
  endtask

  task automatic queue_name(input int len, input int fill);
    ssn_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data = (fill < 0) ? 8'($urandom) : 8'(fill);
      it.last = (i == len - 1);
      name_q.push_back(it);
    end
  endtask

  // Hold until every byte is taken and every character checked.
  task automatic drain();
    while (name_q.size() != 0 || nid_q.size() != 0 || in_if.valid) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Record an accepted name byte and predict from it.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      predict_nid(in_if.name_byte, in_if.last_byte);
      taken_cnt++;
    end
  end

  // Driver: offer the head of the queue, hold it until taken, idle at random, stall output ready at random.
  always @(negedge clk_i) begin
    bit done;
    done = (taken_cnt != taken_seen);
    taken_seen = taken_cnt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.name_byte <= '0;
      in_if.last_byte <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (done) void'(name_q.pop_front());
      if (!in_if.valid || done) begin
        if (name_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.name_byte <= name_q[0].data;
          in_if.last_byte <= name_q[0].last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each accepted character with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (nid_q.size() == 0) begin
        $display("%0t: unexpected char exp=none act=%0d last=%0b",
                 $time, out_if.nid_char, out_if.last_char);
        errors++;
      end else begin
        if (out_if.nid_char !== nid_q[0].ch) begin
          $display("%0t: nid_char mismatch exp=%0d act=%0d",
                   $time, nid_q[0].ch, out_if.nid_char);
          errors++;
        end
        if (out_if.last_char !== nid_q[0].last) begin
          $display("%0t: last_char mismatch exp=%0b act=%0b",
                   $time, nid_q[0].last, out_if.last_char);
          errors++;
        end
        void'(nid_q.pop_front());
      end
    end
  end

  // Stimulus: reset, directed names, then phases over settings and idle and stall patterns.
  initial begin
    int phase_words;
    int len;
    int salt_lens[10] = '{0, 16, 31, 1, 8, 9, 15, 17, 7, 0};
    cfg_we_i = 1'b0;
    cfg_idx_i = RegMode;
    cfg_data_i = '0;
    chain_reset();
    m_mode = '0; m_salt_first = '0; m_salt_last = '0; m_salt_len = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, single-byte extremes, a short random name and a 20-byte name.
    queue_name(1, 8'h00);
    queue_name(1, 8'hFF);
    queue_name(3, -1);
    queue_name(20, 8'hA5);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 66 : 21) : 0;
      recv_stall_pct = (ph % 4 == 2) ? 66 : ((ph % 4 == 3) ? 21 : 0);
      write_reg(RegMode, (ph < 8) ? 64'(ph) : 64'($urandom_range(7)));
      write_reg(RegSaltFirst, (ph == 0) ? 64'd0 :
                (ph == 1) ? {64{1'b1}} : {$urandom, $urandom});
      write_reg(RegSaltLast, (ph == 0) ? 64'd0 :
                (ph == 1) ? {64{1'b1}} : {$urandom, $urandom});
      write_reg(RegSaltLen, 64'(salt_lens[ph]));
      phase_words = 0;
      while (phase_words < 22) begin
        if ($urandom_range(99) < 70) len = $urandom_range(12, 1);
        else len = $urandom_range(72, 39);
        queue_name(len, -1);
        phase_words += len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #8ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/ssn_pkg.sv
design/ssn_stream_if.sv
design/ssn_front.sv
design/ssn_back.sv
design/salted_sha1_nid_encoder.sv
tb/salted_sha1_nid_encoder_tb.sv
